// File: sv/car_pkg.sv
// Package with shared types, constants and the arctangent table for the rate step block.
package car_pkg;

  localparam int unsigned ANG_W = 34;
  localparam int unsigned CX_W = 40;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [CX_W-1:0] GAIN_Q30 = CX_W'(652032874);
  localparam logic [30:0] ONE_Q30 = 31'h40000000;
  localparam logic [34:0] SAT_LIMIT = 35'h200000000;

  localparam logic [1:0] REG_PERIOD = 2'd0;
  localparam logic [1:0] REG_BASE = 2'd1;
  localparam logic [1:0] REG_FLOOR = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MOD, ST_ANG, ST_COS, ST_PREV, ST_SEL, ST_MUL1, ST_MUL2,
    ST_DIV1, ST_RMUL, ST_DIV2, ST_FIN, ST_OUT
  } car_state_e;

  typedef enum logic [1:0] {
    DIVSEL_MOD, DIVSEL_ANG, DIVSEL_RATIO
  } car_divsel_e;

  typedef struct packed {
    logic         load;
    logic         div_start;
    car_divsel_e  div_sel;
    logic         cos_start;
    logic         cos_prev;
    logic         mul_first;
    logic         mul_second;
    logic         ratio_load;
    logic         finish;
  } car_cmd_t;

  typedef struct packed {
    logic pass;
    logic div_done;
    logic cos_done;
    logic closed;
    logic need_prev;
  } car_sts_t;

  function automatic logic [31:0] atan_q30(input logic [5:0] i);
    logic [31:0] v;
    case (i)
      6'd0: v = 32'd843314857;   6'd1: v = 32'd497837829;
      6'd2: v = 32'd263043837;   6'd3: v = 32'd133525159;
      6'd4: v = 32'd67021687;    6'd5: v = 32'd33543516;
      6'd6: v = 32'd16775851;    6'd7: v = 32'd8388437;
      6'd8: v = 32'd4194283;     6'd9: v = 32'd2097149;
      6'd10: v = 32'd1048576;    6'd11: v = 32'd524288;
      6'd12: v = 32'd262144;     6'd13: v = 32'd131072;
      6'd14: v = 32'd65536;      6'd15: v = 32'd32768;
      6'd16: v = 32'd16384;      6'd17: v = 32'd8192;
      6'd18: v = 32'd4096;       6'd19: v = 32'd2048;
      6'd20: v = 32'd1024;       6'd21: v = 32'd512;
      6'd22: v = 32'd256;        6'd23: v = 32'd128;
      6'd24: v = 32'd64;         6'd25: v = 32'd32;
      6'd26: v = 32'd16;         6'd27: v = 32'd8;
      6'd28: v = 32'd4;          6'd29: v = 32'd2;
      6'd30: v = 32'd1;          6'd31: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// File: sv/cosine_annealing_rate_step.sv
// Cosine annealing learning-rate step: one request in, one result out.
// Pass-through requests skip the arithmetic; the closed and recursive forms run on the
// bit-serial divider and the iterative CORDIC.
// One request at a time; the next is accepted only once the result has been taken and the block is idle again.
// Reset clears the step counter and loads the default period, base and floor rates.
module cosine_annealing_rate_step import car_pkg::*; #(
  parameter int unsigned CORDIC_ITERATIONS = 24,
  parameter int unsigned COUNTER_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] current_rate_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] next_rate_o,
  output logic        passed_through_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  car_cmd_t cmd;
  car_sts_t sts;

  assign cfg_ready_o = 1'b1;

  car_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o,
    .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  car_dp #(
    .CORDIC_ITERATIONS(CORDIC_ITERATIONS),
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_dp (
    .clk_i, .rst_ni,
    .cmd_i(cmd), .sts_o(sts),
    .cfg_valid_i, .cfg_index_i, .cfg_data_i,
    .current_rate_i, .next_rate_o, .passed_through_o
  );

endmodule

// File: sv/car_div.sv
// Restoring divider producing one quotient bit per cycle.
module car_div import car_pkg::*; #(
  parameter int unsigned W = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] num_i,
  input  logic [W-1:0] den_i,
  output logic         done_o,
  output logic [W-1:0] quo_o,
  output logic [W-1:0] rem_o
);

  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0] quo_q, quo_d, rem_q, rem_d, den_q, den_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d, done_q, done_d;
  logic [W:0] trial;

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    den_d = den_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial = {rem_q, quo_q[W-1]} - {1'b0, den_q};
    if (start_i) begin
      quo_d = num_i;
      rem_d = '0;
      den_d = den_i;
      cnt_d = CW'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[W]) begin
        rem_d = trial[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[W-2:0], quo_q[W-1]};
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o = quo_q;
  assign rem_o = rem_q;

endmodule

// File: sv/car_cordic.sv
// Iterative rotation-mode CORDIC returning a clamped cosine in Q1.30.
module car_cordic import car_pkg::*; #(
  parameter int unsigned ITER = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [ANG_W-1:0] angle_i,
  output logic             done_o,
  output logic [30:0]      cos_o
);

  logic signed [CX_W-1:0] x_q, x_d, y_q, y_d;
  logic signed [ANG_W+1:0] z_q, z_d;
  logic [5:0] i_q, i_d;
  logic busy_q, busy_d, done_q, done_d;
  logic signed [CX_W-1:0] dx, dy;
  logic signed [ANG_W+1:0] t;

  always_comb begin
    dx = y_q >>> i_q;
    dy = x_q >>> i_q;
    t = $signed({{(ANG_W-30){1'b0}}, atan_q30(i_q)});
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    i_d = i_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      x_d = GAIN_Q30;
      y_d = '0;
      z_d = $signed({2'b00, angle_i});
      i_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!z_q[ANG_W+1]) begin
        x_d = x_q - dx;
        y_d = y_q + dy;
        z_d = z_q - t;
      end else begin
        x_d = x_q + dx;
        y_d = y_q - dy;
        z_d = z_q + t;
      end
      i_d = i_q + 6'd1;
      if (i_q == 6'(ITER - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      i_q <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  always_comb begin
    if (x_q[CX_W-1]) begin
      cos_o = '0;
    end else if (x_q > $signed({{(CX_W-31){1'b0}}, ONE_Q30})) begin
      cos_o = ONE_Q30;
    end else begin
      cos_o = x_q[30:0];
    end
  end

  assign done_o = done_q;

endmodule

// File: sv/car_ctrl.sv
// Controller state machine sequencing the rate step datapath.
module car_ctrl import car_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  car_sts_t sts_i,
  output car_cmd_t cmd_o
);

  car_state_e state_q, state_d;
  logic prev_q, prev_d;
  logic ang_q, ang_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      prev_q <= 1'b0;
      ang_q <= 1'b0;
    end else begin
      state_q <= state_d;
      prev_q <= prev_d;
      ang_q <= ang_d;
    end
  end

  always_comb begin
    state_d = state_q;
    prev_d = prev_q;
    ang_d = ang_q;
    cmd_o = '0;
    cmd_o.div_sel = DIVSEL_MOD;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = ST_MOD;
        end
      end
      ST_MOD: begin
        if (sts_i.pass) begin
          cmd_o.finish = 1'b1;
          state_d = ST_OUT;
        end else begin
          prev_d = 1'b0;
          ang_d = 1'b0;
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel = DIVSEL_MOD;
          cmd_o.cos_prev = 1'b0;
          state_d = ST_ANG;
        end
      end
      ST_ANG: begin
        cmd_o.cos_prev = prev_q;
        cmd_o.div_sel = ang_q ? DIVSEL_ANG : DIVSEL_MOD;
        if (sts_i.div_done) begin
          if (!ang_q) begin
            ang_d = 1'b1;
            cmd_o.div_start = 1'b1;
            cmd_o.div_sel = DIVSEL_ANG;
          end else begin
            cmd_o.cos_start = 1'b1;
            state_d = ST_COS;
          end
        end
      end
      ST_COS: begin
        cmd_o.cos_prev = prev_q;
        if (sts_i.cos_done) begin
          if (!prev_q && sts_i.need_prev) begin
            state_d = ST_PREV;
          end else begin
            state_d = ST_SEL;
          end
        end
      end
      ST_PREV: begin
        prev_d = 1'b1;
        ang_d = 1'b0;
        cmd_o.cos_prev = 1'b1;
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel = DIVSEL_MOD;
        state_d = ST_ANG;
      end
      ST_SEL: begin
        cmd_o.mul_first = 1'b1;
        state_d = ST_MUL1;
      end
      ST_MUL1: begin
        if (sts_i.closed) begin
          cmd_o.mul_second = 1'b1;
          state_d = ST_MUL2;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel = DIVSEL_RATIO;
          state_d = ST_DIV1;
        end
      end
      ST_MUL2: begin
        cmd_o.finish = 1'b1;
        state_d = ST_OUT;
      end
      ST_DIV1: begin
        cmd_o.div_sel = DIVSEL_RATIO;
        if (sts_i.div_done) begin
          cmd_o.ratio_load = 1'b1;
          state_d = ST_RMUL;
        end
      end
      ST_RMUL: begin
        cmd_o.mul_second = 1'b1;
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel = DIVSEL_RATIO;
        state_d = ST_DIV2;
      end
      ST_DIV2: begin
        cmd_o.div_sel = DIVSEL_RATIO;
        if (sts_i.div_done) begin
          cmd_o.ratio_load = 1'b1;
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd_o.finish = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// File: sv/car_dp.sv
// Datapath with step counter, fold logic, CORDIC, divider and product registers.
module car_dp import car_pkg::*; #(
  parameter int unsigned CORDIC_ITERATIONS = 24,
  parameter int unsigned COUNTER_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  car_cmd_t    cmd_i,
  output car_sts_t    sts_o,
  input  logic        cfg_valid_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic [31:0] current_rate_i,
  output logic [31:0] next_rate_o,
  output logic        passed_through_o
);

  localparam int unsigned DW = 64;

  logic [15:0] period_q;
  logic [31:0] base_q, floor_q, cur_q;
  logic [COUNTER_WIDTH-1:0] cnt_q, s_q;
  logic [30:0] cn_q, cp_q;
  logic [34:0] t_q;
  logic closed_q;
  logic [31:0] res_q;
  logic pass_q;

  logic [COUNTER_WIDTH-1:0] x_sel;
  logic [DW-1:0] div_num, div_den, quo, rem;
  logic div_done;
  logic [16:0] two_p, r_fold;
  logic [ANG_W-1:0] angle;
  logic cos_done;
  logic [30:0] cos_val;
  logic [32:0] dmag;
  logic [63:0] prod;
  logic [32:0] diff_base, diff_cur;
  logic [34:0] qsat;
  logic signed [35:0] sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= 16'd100;
      base_q <= 32'd1073742;
      floor_q <= '0;
      cnt_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_PERIOD: period_q <= cfg_data_i[15:0];
          REG_BASE: base_q <= cfg_data_i;
          REG_FLOOR: floor_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        cnt_q <= cnt_q + COUNTER_WIDTH'(1);
      end
    end
  end

  assign two_p = {period_q, 1'b0};
  assign x_sel = cmd_i.cos_prev ? s_q - COUNTER_WIDTH'(1) : s_q;
  assign r_fold = (rem[16:0] > {1'b0, period_q}) ? two_p - rem[16:0] : rem[16:0];

  always_comb begin
    case (cmd_i.div_sel)
      DIVSEL_MOD: begin
        div_num = DW'(x_sel);
        div_den = DW'(two_p);
      end
      DIVSEL_ANG: begin
        div_num = DW'(HALF_PI_Q30 * {31'd0, r_fold});
        div_den = DW'(period_q);
      end
      default: begin
        div_num = prod;
        div_den = DW'(cp_q);
      end
    endcase
  end

  car_div #(.W(DW)) u_div (
    .clk_i, .rst_ni,
    .start_i(cmd_i.div_start),
    .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(quo), .rem_o(rem)
  );

  assign angle = quo[ANG_W-1:0];

  car_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic (
    .clk_i, .rst_ni,
    .start_i(cmd_i.cos_start),
    .angle_i(angle),
    .done_o(cos_done), .cos_o(cos_val)
  );

  assign qsat = (|quo[DW-1:35] || quo[34:0] > SAT_LIMIT) ? SAT_LIMIT : quo[34:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      s_q <= cnt_q;
      cur_q <= current_rate_i;
      closed_q <= 1'b0;
    end
    if (cos_done) begin
      if (cmd_i.cos_prev) begin
        cp_q <= cos_val;
      end else begin
        cn_q <= cos_val;
      end
    end
    // The remainder here is (s-1) mod 2P.
    if (cmd_i.div_start && cmd_i.div_sel == DIVSEL_ANG && cmd_i.cos_prev) begin
      closed_q <= (rem[16:0] == {1'b0, period_q});
    end
    if (cmd_i.mul_first || cmd_i.mul_second) begin
      t_q <= 35'(prod >> 30);
    end
    if (cmd_i.ratio_load) begin
      t_q <= qsat;
    end
    if (cmd_i.finish) begin
      pass_q <= sts_o.pass;
      res_q <= sts_o.pass ? cur_q : (sum[35] ? 32'd0 : (|sum[34:32] ? 32'hffffffff : sum[31:0]));
    end
  end

  // Closed form also when the previous cosine is zero.
  logic use_closed;
  assign use_closed = closed_q || (cp_q == '0);

  assign diff_base = {1'b0, base_q} - {1'b0, floor_q};
  assign diff_cur = {1'b0, cur_q} - {1'b0, floor_q};
  assign dmag = use_closed ? (diff_base[32] ? -diff_base : diff_base)
                           : (diff_cur[32] ? -diff_cur : diff_cur);

  logic [33:0] mul_a;
  logic [30:0] mul_b;
  assign mul_a = cmd_i.mul_second ? t_q[33:0] : {1'b0, dmag};
  assign mul_b = cn_q;
  assign prod = {30'd0, mul_a} * {33'd0, mul_b};

  logic neg;
  assign neg = use_closed ? diff_base[32] : diff_cur[32];
  logic [34:0] tsat;
  assign tsat = (t_q > SAT_LIMIT) ? SAT_LIMIT : t_q;
  assign sum = neg ? $signed({4'd0, floor_q}) - $signed({1'b0, tsat})
                   : $signed({4'd0, floor_q}) + $signed({1'b0, tsat});

  assign sts_o.pass = (s_q == '0) || (period_q == '0);
  assign sts_o.div_done = div_done;
  assign sts_o.cos_done = cos_done;
  assign sts_o.closed = use_closed;
  assign sts_o.need_prev = 1'b1;

  assign next_rate_o = res_q;
  assign passed_through_o = pass_q;

endmodule

// File: tb/car_checker.sv
// Checker for the cosine annealing rate step: predicts each result and compares it.
module car_checker import car_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [31:0] current_rate_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] next_rate_i,
  input  logic        passed_through_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output int          pending_o,
  output int          errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ITERS = 24;
  localparam longint unsigned HALF_PI = 64'd1686629713;
  localparam longint QUARTER_PI = 64'sd843314857;
  localparam longint GAIN = 64'sd652032874;
  localparam longint ONE = 64'sd1073741824;
  localparam longint unsigned CLAMP = 64'd8589934592;

  typedef struct packed {
    logic [31:0] rate;
    logic        passed;
  } rate_result_t;

  rate_result_t expected_rates[$];
  logic [15:0] period_q;
  logic [31:0] base_q;
  logic [31:0] floor_q;
  logic [31:0] step_q;

  function automatic longint floor_shift(longint v, int unsigned i);
    longint unsigned u;
    if (v >= 0) return v >>> i;
    u = -v;
    return -longint'((u + ((64'd1 << i) - 64'd1)) >> i);
  endfunction

  function automatic longint arctan_step(int unsigned i);
    longint unsigned sum;
    longint unsigned term;
    bit add;
    sum = 0;
    add = 1;
    if (i == 0) return QUARTER_PI;
    for (int unsigned k = 1; i * k <= 60; k += 2) begin
      term = (64'd1 << (60 - i * k)) / k;
      if (add) sum += term;
      else sum -= term;
      add = !add;
    end
    return longint'((sum + (64'd1 << 29)) >> 30);
  endfunction

  function automatic longint unsigned half_cosine(longint unsigned x, longint unsigned p);
    longint unsigned r;
    longint cx, cy, z, dx, dy, a;
    r = x % (2 * p);
    cx = GAIN;
    cy = 0;
    if (r > p) r = 2 * p - r;
    z = longint'((HALF_PI * r) / p);
    for (int unsigned i = 0; i < ITERS; i++) begin
      dx = floor_shift(cy, i);
      dy = floor_shift(cx, i);
      a = arctan_step(i);
      if (z >= 0) begin
        cx -= dx; cy += dy; z -= a;
      end else begin
        cx += dx; cy -= dy; z += a;
      end
    end
    if (cx < 0) cx = 0;
    if (cx > ONE) cx = ONE;
    return longint'(cx);
  endfunction

  function automatic logic [31:0] offset_rate(logic [31:0] fl, bit neg, longint unsigned t);
    longint v;
    if (t > CLAMP) t = CLAMP;
    v = neg ? longint'({32'd0, fl}) - longint'(t) : longint'({32'd0, fl}) + longint'(t);
    if (v < 0) return 32'd0;
    if (v > 64'sd4294967295) return 32'hFFFF_FFFF;
    return v[31:0];
  endfunction

  function automatic logic [31:0] closed_rate(longint unsigned s, longint unsigned p);
    longint unsigned c, m, t;
    longint d;
    c = half_cosine(s, p);
    d = longint'({32'd0, base_q}) - longint'({32'd0, floor_q});
    m = (d < 0) ? -d : d;
    t = (((m * c) >> 30) * c) >> 30;
    return offset_rate(floor_q, d < 0, t);
  endfunction

  function automatic rate_result_t predict_rate(logic [31:0] cur);
    rate_result_t res;
    longint unsigned s, p, cn, cp, m, t;
    longint d;
    s = step_q;
    p = period_q;
    res.passed = 1'b0;
    if (s == 0 || p == 0) begin
      res.rate = cur;
      res.passed = 1'b1;
    end else if ((s - 1) % (2 * p) == p) begin
      res.rate = closed_rate(s, p);
    end else begin
      cn = half_cosine(s, p);
      cp = half_cosine(s - 1, p);
      if (cp == 0) begin
        res.rate = closed_rate(s, p);
      end else begin
        d = longint'({32'd0, cur}) - longint'({32'd0, floor_q});
        m = (d < 0) ? -d : d;
        t = (m * cn) / cp;
        if (t > CLAMP) t = CLAMP;
        t = (t * cn) / cp;
        res.rate = offset_rate(floor_q, d < 0, t);
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rate_result_t exp_r;
    if (!rst_ni) begin
      period_q <= 16'd100;
      base_q <= 32'd1073742;
      floor_q <= 32'd0;
      step_q <= 32'd0;
      errors_o <= 0;
      pending_o <= 0;
      expected_rates.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_PERIOD: period_q <= cfg_data_i[15:0];
          REG_BASE: base_q <= cfg_data_i;
          REG_FLOOR: floor_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        expected_rates.push_back(predict_rate(current_rate_i));
        step_q <= step_q + 32'd1;
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_rates.size() == 0) begin
          if (errors_o < 10) $display("Unexpected result: rate %h passed %b",
                                      next_rate_i, passed_through_i);
          errors_o <= errors_o + 1;
        end else begin
          exp_r = expected_rates.pop_front();
          if (exp_r.rate !== next_rate_i || exp_r.passed !== passed_through_i) begin
            if (errors_o < 10) $display("Mismatch: expected rate %h passed %b, got %h %b",
                                        exp_r.rate, exp_r.passed, next_rate_i,
                                        passed_through_i);
            errors_o <= errors_o + 1;
          end
        end
      end
      pending_o <= expected_rates.size();
    end
  end
endmodule

// File: tb/tb_top.sv
// Top of the testbench: clock, reset, request stimulus and the final verdict.
module tb_top import car_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] current_rate = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] next_rate;
  logic        passed_through;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_PERIOD;
  logic [31:0] cfg_data = '0;
  int          pending;
  int          errors;
  int          out_stall = 0;
  bit          no_idle = 1'b0;
  logic [31:0] base_now = 32'd1073742;

  always #2 clk = ~clk;

  cosine_annealing_rate_step i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .current_rate_i(current_rate),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .next_rate_o(next_rate), .passed_through_o(passed_through),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  car_checker i_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .current_rate_i(current_rate),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .next_rate_i(next_rate), .passed_through_i(passed_through),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .pending_o(pending), .errors_o(errors)
  );

  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      out_stall = no_idle ? 0 : $urandom_range(0, 4);
      out_ready <= (out_stall == 0);
    end else if (out_stall > 0) begin
      out_stall--;
      out_ready <= (out_stall == 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_rate(logic [31:0] rate);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    current_rate <= rate;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_BASE) base_now = value;
  endtask

  function automatic logic [31:0] random_rate();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return base_now;
      3: return base_now + $urandom_range(0, 255) - 128;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    logic [15:0] per;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_rate(32'h1234_5678);
    send_rate(32'd0);
    send_rate(32'hFFFF_FFFF);
    write_reg(REG_PERIOD, 32'd1);
    write_reg(REG_BASE, 32'hFFFF_FFFF);
    write_reg(REG_FLOOR, 32'd0);
    for (int i = 0; i < 5; i++) send_rate(i[0] ? 32'hFFFF_FFFF : 32'd0);
    write_reg(REG_FLOOR, 32'hFFFF_FFFF);
    write_reg(REG_BASE, 32'd0);
    for (int i = 0; i < 5; i++) send_rate(i[0] ? 32'd0 : 32'hFFFF_FFFF);
    write_reg(REG_PERIOD, 32'd0);
    send_rate(32'hA5A5_A5A5);
    send_rate(32'h5A5A_5A5A);
    write_reg(REG_PERIOD, 32'hFFFF_FFFF);
    write_reg(REG_FLOOR, 32'd0);
    write_reg(REG_BASE, 32'h4000_0000);
    for (int i = 0; i < 5; i++) send_rate(32'h4000_0000);
    for (int ph = 0; ph < 12; ph++) begin
      case ($urandom_range(0, 7))
        0: per = 16'd0;
        1: per = 16'hFFFF;
        2: per = 16'($urandom_range(1, 4));
        3: per = 16'($urandom);
        default: per = 16'($urandom_range(1, 60));
      endcase
      write_reg(REG_PERIOD, {16'($urandom), per});
      write_reg(REG_BASE, ($urandom_range(0, 5) == 0) ? 32'hFFFF_FFFF : $urandom);
      write_reg(REG_FLOOR, ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom);
      no_idle = (ph % 4 == 3);
      for (int i = 0; i < 150; i++) send_rate(random_rate());
      no_idle = 1'b0;
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
